@@ hw/rtl/mhpq_pkg.sv @@
`timescale 1ns / 1ps

package mhpq_pkg;

  // Heap depth; slots are numbered 1..CAPACITY.
  localparam int CAPACITY = 64;

  // Fixed widths of the word fields.
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 7;

  // Slot index wide enough to hold CAPACITY itself; memory address is slot - 1.
  localparam int SLOT_W = $clog2(CAPACITY + 1);
  localparam int ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  typedef logic signed [VALUE_W-1:0] value_t;
  typedef logic [SLOT_W-1:0]         slot_t;
  typedef logic [ADDR_W-1:0]         addr_t;

  typedef enum logic {
    MODE_PUSH = 1'b0,
    MODE_POP  = 1'b1
  } mode_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_UP_RD,
    S_UP_CMP,
    S_POP_ROOT,
    S_POP_LAST,
    S_DN_RDL,
    S_DN_RDR,
    S_DN_CMP,
    S_DONE
  } state_e;

  // Result of one operation, handed from the sequencer to the output register.
  typedef struct packed {
    value_t             popped;
    status_e            status;
    logic [COUNT_W-1:0] count;
  } res_t;

endpackage

@@ hw/rtl/mhpq_if.sv @@
`timescale 1ns / 1ps

// Input channel: one operation word.
interface mhpq_in_if;
  logic                                valid;
  logic                                ready;
  logic                                mode;
  logic signed [mhpq_pkg::VALUE_W-1:0] value;

  modport source (output valid, output mode, output value, input ready);
  modport sink   (input valid, input mode, input value, output ready);
endinterface

// Output channel: one result word per operation.
interface mhpq_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [mhpq_pkg::VALUE_W-1:0] popped;
  logic [mhpq_pkg::STATUS_W-1:0]       status;
  logic [mhpq_pkg::COUNT_W-1:0]        count;

  modport source (output valid, output popped, output status, output count, input ready);
  modport sink   (input valid, input popped, input status, input count, output ready);
endinterface

@@ hw/rtl/mhpq_cmp.sv @@
`timescale 1ns / 1ps

// Shared signed comparator: lt_o is high when a_i is strictly below b_i.
module mhpq_cmp (
  input  mhpq_pkg::value_t a_i,
  input  mhpq_pkg::value_t b_i,
  output logic             lt_o
);

  assign lt_o = (a_i < b_i);

endmodule

@@ hw/rtl/mhpq_seq.sv @@
`timescale 1ns / 1ps

// Heap sequencer: owns the heap memory and walks sift up / sift down with
// one shared comparator. The moving value is held in a register and only
// written back once its final slot is known.
module mhpq_seq (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic                  mode_i,
  input  mhpq_pkg::value_t      value_i,
  output logic                  idle_o,
  output logic                  res_valid_o,
  input  logic                  res_ack_i,
  output mhpq_pkg::res_t        res_o
);

  localparam int SW = mhpq_pkg::SLOT_W;

  mhpq_pkg::state_e  state_q, state_d;
  mhpq_pkg::slot_t   cnt_q, cnt_d;
  mhpq_pkg::slot_t   n_q, n_d;
  mhpq_pkg::slot_t   k_q, k_d;
  mhpq_pkg::slot_t   best_idx_q, best_idx_d;
  mhpq_pkg::value_t  v_q, v_d;
  mhpq_pkg::value_t  best_val_q, best_val_d;
  mhpq_pkg::value_t  popped_q, popped_d;
  mhpq_pkg::status_e status_q, status_d;
  logic              has_r_q, has_r_d;

  mhpq_pkg::value_t  mem_q [mhpq_pkg::CAPACITY];
  mhpq_pkg::value_t  rdata_q;
  mhpq_pkg::slot_t   rd_slot, wr_slot;
  mhpq_pkg::value_t  wdata;
  logic              we;

  mhpq_pkg::value_t  cmp_a, cmp_b;
  logic              cmp_lt;

  logic [SW:0]       l_slot, r_slot, n_ext;
  logic              l_in, r_in;
  mhpq_pkg::slot_t   parent;

  assign l_slot = {k_q, 1'b0};
  assign r_slot = {k_q, 1'b1};
  assign n_ext  = {1'b0, n_q};
  assign l_in   = (l_slot <= n_ext);
  assign r_in   = (r_slot <= n_ext);
  assign parent = k_q >> 1;

  mhpq_cmp u_cmp (
    .a_i  (cmp_a),
    .b_i  (cmp_b),
    .lt_o (cmp_lt)
  );

  // Heap memory: one write and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[mhpq_pkg::ADDR_W'(wr_slot - SW'(1))] <= wdata;
    end
    rdata_q <= mem_q[mhpq_pkg::ADDR_W'(rd_slot - SW'(1))];
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      mhpq_pkg::S_IDLE: begin
        if (start_i) begin
          if (mode_i == mhpq_pkg::MODE_POP) begin
            state_d = (cnt_q == '0) ? mhpq_pkg::S_DONE : mhpq_pkg::S_POP_ROOT;
          end else begin
            state_d = (cnt_q >= SW'(mhpq_pkg::CAPACITY)) ? mhpq_pkg::S_DONE
                                                         : mhpq_pkg::S_UP_RD;
          end
        end
      end
      mhpq_pkg::S_UP_RD: begin
        state_d = (k_q == SW'(1)) ? mhpq_pkg::S_DONE : mhpq_pkg::S_UP_CMP;
      end
      mhpq_pkg::S_UP_CMP: begin
        state_d = cmp_lt ? mhpq_pkg::S_UP_RD : mhpq_pkg::S_DONE;
      end
      mhpq_pkg::S_POP_ROOT: state_d = mhpq_pkg::S_POP_LAST;
      mhpq_pkg::S_POP_LAST: state_d = mhpq_pkg::S_DN_RDL;
      mhpq_pkg::S_DN_RDL: begin
        state_d = l_in ? mhpq_pkg::S_DN_RDR : mhpq_pkg::S_DONE;
      end
      mhpq_pkg::S_DN_RDR: state_d = mhpq_pkg::S_DN_CMP;
      mhpq_pkg::S_DN_CMP: begin
        state_d = (best_idx_d == k_q) ? mhpq_pkg::S_DONE : mhpq_pkg::S_DN_RDL;
      end
      mhpq_pkg::S_DONE: begin
        if (res_ack_i) begin
          state_d = mhpq_pkg::S_IDLE;
        end
      end
      default: state_d = mhpq_pkg::S_IDLE;
    endcase
  end

  // Memory and comparator control.
  always_comb begin
    rd_slot = SW'(1);
    wr_slot = k_q;
    wdata   = v_q;
    we      = 1'b0;
    cmp_a   = v_q;
    cmp_b   = rdata_q;
    case (state_q)
      mhpq_pkg::S_UP_RD: begin
        rd_slot = parent;
        we      = (k_q == SW'(1));
      end
      mhpq_pkg::S_UP_CMP: begin
        cmp_a = rdata_q;
        cmp_b = v_q;
        we    = 1'b1;
        wdata = cmp_lt ? rdata_q : v_q;
      end
      mhpq_pkg::S_POP_ROOT: rd_slot = cnt_q;
      mhpq_pkg::S_DN_RDL: begin
        rd_slot = l_slot[SW-1:0];
        we      = !l_in;
      end
      mhpq_pkg::S_DN_RDR: begin
        rd_slot = r_slot[SW-1:0];
      end
      mhpq_pkg::S_DN_CMP: begin
        cmp_a = best_val_q;
        we    = 1'b1;
        wdata = best_val_d;
      end
      default: ;
    endcase
  end

  // Datapath registers.
  always_comb begin
    cnt_d      = cnt_q;
    n_d        = n_q;
    k_d        = k_q;
    v_d        = v_q;
    best_val_d = best_val_q;
    best_idx_d = best_idx_q;
    has_r_d    = has_r_q;
    popped_d   = popped_q;
    status_d   = status_q;
    case (state_q)
      mhpq_pkg::S_IDLE: begin
        popped_d = '0;
        status_d = mhpq_pkg::STAT_OK;
        n_d      = cnt_q;
        v_d      = value_i;
        k_d      = cnt_q + SW'(1);
        if (mode_i == mhpq_pkg::MODE_POP) begin
          if (cnt_q == '0) begin
            status_d = mhpq_pkg::STAT_EMPTY;
          end
        end else if (cnt_q >= SW'(mhpq_pkg::CAPACITY)) begin
          status_d = mhpq_pkg::STAT_FULL;
        end else begin
          n_d = cnt_q + SW'(1);
        end
      end
      mhpq_pkg::S_UP_CMP: begin
        if (cmp_lt) begin
          k_d = parent;
        end
      end
      mhpq_pkg::S_POP_ROOT: begin
        popped_d = rdata_q;
        n_d      = cnt_q - SW'(1);
      end
      mhpq_pkg::S_POP_LAST: begin
        v_d = rdata_q;
        k_d = SW'(1);
      end
      mhpq_pkg::S_DN_RDR: begin
        // Left child wins only if strictly greater than the moving value.
        has_r_d    = r_in;
        best_val_d = cmp_lt ? rdata_q : v_q;
        best_idx_d = cmp_lt ? l_slot[SW-1:0] : k_q;
      end
      mhpq_pkg::S_DN_CMP: begin
        if (has_r_q && cmp_lt) begin
          best_val_d = rdata_q;
          best_idx_d = r_slot[SW-1:0];
        end
        if (best_idx_d != k_q) begin
          k_d = best_idx_d;
        end
      end
      mhpq_pkg::S_DONE: begin
        if (res_ack_i) begin
          cnt_d = n_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mhpq_pkg::S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q        <= n_d;
    k_q        <= k_d;
    v_q        <= v_d;
    best_val_q <= best_val_d;
    best_idx_q <= best_idx_d;
    has_r_q    <= has_r_d;
    popped_q   <= popped_d;
    status_q   <= status_d;
  end

  assign idle_o       = (state_q == mhpq_pkg::S_IDLE);
  assign res_valid_o  = (state_q == mhpq_pkg::S_DONE);
  assign res_o.popped = popped_q;
  assign res_o.status = status_q;
  assign res_o.count  = mhpq_pkg::COUNT_W'(n_q);

endmodule

@@ hw/rtl/max_heap_priority_queue.sv @@
`timescale 1ns / 1ps

// Binary max-heap priority queue of signed 32-bit values, holding up to
// mhpq_pkg::CAPACITY entries. Each input word is either a push of its value
// or a pop of the current maximum, and each gives exactly one result word
// carrying the popped value (zero unless a pop succeeded), a status (ok,
// push refused because full, or pop refused because empty) and the entry
// count after the operation. A refused operation leaves the heap untouched.
// Operations are handled one at a time by a small sequencer that drives the
// heap memory (one write port and one registered read port) and one shared
// comparator. The time per operation is set by the memory read latency and
// by how far the value moves: a push climbs at most log2 of the capacity
// levels and a pop sinks at most one level fewer. Any wait for the output
// register to drain adds to the time. The input is ready whenever the
// sequencer is idle, even while the previous result word still waits in
// the output register, and the heap contents need no clearing after reset.
module max_heap_priority_queue (
  input  logic       clk_i,
  input  logic       rst_ni,
  mhpq_in_if.sink    in_i,
  mhpq_out_if.source out_o
);

  logic           seq_idle;
  logic           seq_res_valid;
  logic           seq_res_ack;
  mhpq_pkg::res_t seq_res;

  logic           out_valid_q, out_valid_d;
  mhpq_pkg::res_t out_res_q;

  // The sequencer starts on every accepted input word.
  assign in_i.ready = seq_idle;

  mhpq_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (in_i.valid && seq_idle),
    .mode_i      (in_i.mode),
    .value_i     (in_i.value),
    .idle_o      (seq_idle),
    .res_valid_o (seq_res_valid),
    .res_ack_i   (seq_res_ack),
    .res_o       (seq_res)
  );

  // The output register takes a finished result when it is empty or when its
  // current word leaves in the same cycle.
  assign seq_res_ack = seq_res_valid && (!out_valid_q || out_o.ready);

  always_comb begin
    out_valid_d = out_valid_q;
    if (seq_res_ack) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (seq_res_ack) begin
      out_res_q <= seq_res;
    end
  end

  assign out_o.valid  = out_valid_q;
  assign out_o.popped = out_res_q.popped;
  assign out_o.status = out_res_q.status;
  assign out_o.count  = out_res_q.count;

endmodule

@@ hw/rtl/mhpq_chk.sv @@
`timescale 1ns / 1ps

module mhpq_chk (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                out_valid_i,
  input logic                                out_ready_i,
  input logic signed [mhpq_pkg::VALUE_W-1:0] out_popped_i,
  input logic [mhpq_pkg::STATUS_W-1:0]       out_status_i,
  input logic [mhpq_pkg::COUNT_W-1:0]        out_count_i
);

  localparam logic [mhpq_pkg::COUNT_W-1:0] FULL_CNT =
    mhpq_pkg::COUNT_W'(mhpq_pkg::CAPACITY);

  // A refused push is only reported with a full heap and no popped value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_status_i == mhpq_pkg::STAT_FULL |->
      out_count_i == FULL_CNT && out_popped_i == '0)
    else $error("refused push without a full heap");

  // A refused pop is only reported with an empty heap and no popped value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_status_i == mhpq_pkg::STAT_EMPTY |->
      out_count_i == '0 && out_popped_i == '0)
    else $error("refused pop without an empty heap");

  // The count reported never exceeds the capacity.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> out_count_i <= FULL_CNT)
    else $error("count above capacity");

  // A stalled result word holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      out_valid_i && $stable(out_popped_i) && $stable(out_status_i)
      && $stable(out_count_i))
    else $error("stalled result changed");

endmodule

bind max_heap_priority_queue mhpq_chk u_mhpq_chk (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .out_popped_i (out_o.popped),
  .out_status_i (out_o.status),
  .out_count_i  (out_o.count)
);

@@ bench/max_heap_priority_queue_test.sv @@
`timescale 1ns / 1ps

// Self-checking bench for the max-heap priority queue. Operation words come
// from a queue that is filled once at time zero, the driver presents them at
// the falling edge, and a monitor samples both channels at the rising edge.
// Every accepted operation is run through a local heap model straight away,
// and its result word is queued. Each result word from the block must match
// the oldest queued result, field by field.
module max_heap_priority_queue_test;
  import mhpq_pkg::*;

  localparam value_t VAL_MIN = 32'sh8000_0000;
  localparam value_t VAL_MAX = 32'sh7fff_ffff;

  // One pending operation. When hold_back is set, the driver keeps the word
  // back until every earlier result word has come out of the block.
  typedef struct {
    mode_e  mode;
    value_t value;
    bit     hold_back;
  } heap_op_t;

  logic clk_i;
  logic rst_ni;

  mhpq_in_if  in_if ();
  mhpq_out_if out_if ();

  max_heap_priority_queue dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  heap_op_t op_queue[$];
  res_t     results_due[$];

  // Local copy of the heap: slots 1..CAPACITY, as in the block itself.
  value_t heap_slots[1:CAPACITY];
  int     heap_fill = 0;

  int   mismatches  = 0;
  int   words_taken = 0;
  logic op_taken    = 1'b0;
  logic sink_hold   = 1'b0;
  logic steady;

  // For one stretch of the run neither side idles, so that the block sees
  // words back to back on both channels.
  assign steady = (words_taken >= 300) && (words_taken < 400);

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Every input of the block holds a known value from the very start.
  initial begin
    rst_ni       = 1'b0;
    in_if.valid  = 1'b0;
    in_if.mode   = MODE_PUSH;
    in_if.value  = '0;
    out_if.ready = 1'b0;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
  end

  task automatic report_mismatch(input string msg);
    if (mismatches < 40) begin
      $display("[%0t] mismatch: %s", $time, msg);
    end
    mismatches++;
  endtask

  // Applies one operation to the local heap and returns the result word
  // that the block must produce for it. A refused operation leaves the heap
  // alone. Swaps happen only on strict less-than, and on a tie during the
  // sift down the left child wins.
  task automatic apply_heap_op(input mode_e mode, input value_t value, output res_t word);
    int     k;
    int     best;
    value_t tmp;
    word.popped = '0;
    word.status = STAT_OK;
    if (mode == MODE_PUSH) begin
      if (heap_fill >= CAPACITY) begin
        word.status = STAT_FULL;
      end else begin
        heap_fill++;
        heap_slots[heap_fill] = value;
        k = heap_fill;
        while (k > 1 && heap_slots[k / 2] < heap_slots[k]) begin
          tmp                = heap_slots[k / 2];
          heap_slots[k / 2]  = heap_slots[k];
          heap_slots[k]      = tmp;
          k                  = k / 2;
        end
      end
    end else begin
      if (heap_fill == 0) begin
        word.status = STAT_EMPTY;
      end else begin
        word.popped   = heap_slots[1];
        heap_slots[1] = heap_slots[heap_fill];
        heap_fill--;
        // With one entry left the root already holds it, so no sift is needed.
        k = 1;
        while (heap_fill > 1) begin
          best = k;
          if (2 * k <= heap_fill && heap_slots[best] < heap_slots[2 * k]) begin
            best = 2 * k;
          end
          if (2 * k + 1 <= heap_fill && heap_slots[best] < heap_slots[2 * k + 1]) begin
            best = 2 * k + 1;
          end
          if (best == k) begin
            break;
          end
          tmp              = heap_slots[best];
          heap_slots[best] = heap_slots[k];
          heap_slots[k]    = tmp;
          k                = best;
        end
      end
    end
    word.count = heap_fill[COUNT_W-1:0];
  endtask

  task automatic add_op(input mode_e mode, input value_t value, input bit hold_back);
    heap_op_t op;
    op.mode      = mode;
    op.value     = value;
    op.hold_back = hold_back;
    op_queue.push_back(op);
  endtask

  // Values come in three flavours: anything at all, a narrow band around
  // zero so that ties are common, and the edges of the signed range.
  function automatic value_t pick_value(input int flavour);
    case (flavour)
      0: return value_t'($urandom);
      1: return value_t'(int'($urandom_range(6)) - 3);
      default: begin
        case ($urandom_range(5))
          0: return VAL_MIN;
          1: return VAL_MAX;
          2: return value_t'(VAL_MIN + 1);
          3: return value_t'(VAL_MAX - 1);
          4: return value_t'(-1);
          default: return '0;
        endcase
      end
    endcase
  endfunction

  function automatic int pick_flavour();
    int roll;
    roll = $urandom_range(9);
    if (roll < 6) return 0;
    if (roll < 8) return 1;
    return 2;
  endfunction

  // Stimulus. The directed part covers a pop from an empty heap, both ends
  // of the signed range, equal values in the heap, popping the very last
  // entry and a second pop from empty. The random part then mixes full
  // cycles (fill past capacity so that pushes are refused, then empty past
  // zero so that pops are refused) with runs of pushes and pops at a
  // random balance.
  initial begin : build_stimulus
    int kind;
    int len;
    int push_pct;
    int flavour;
    bit hold;

    add_op(MODE_POP, value_t'($urandom), 1'b0);
    add_op(MODE_PUSH, VAL_MIN, 1'b0);
    add_op(MODE_PUSH, VAL_MAX, 1'b0);
    add_op(MODE_PUSH, '0, 1'b0);
    add_op(MODE_PUSH, value_t'(-1), 1'b0);
    add_op(MODE_PUSH, value_t'(1), 1'b0);
    add_op(MODE_PUSH, value_t'(5), 1'b0);
    add_op(MODE_PUSH, value_t'(5), 1'b0);
    add_op(MODE_PUSH, value_t'(5), 1'b0);
    add_op(MODE_PUSH, VAL_MAX, 1'b0);
    for (int i = 0; i < 9; i++) begin
      add_op(MODE_POP, value_t'($urandom), 1'b0);
    end
    add_op(MODE_POP, value_t'($urandom), 1'b0);

    // The first random word always waits for the directed part to drain.
    hold = 1'b1;
    kind = 0;
    while (op_queue.size() < 550) begin
      if (kind == 0) begin
        // A full cycle: 67 pushes overrun capacity whatever the fill level.
        flavour = $urandom_range(2);
        for (int i = 0; i < CAPACITY + 3 && op_queue.size() < 550; i++) begin
          add_op(MODE_PUSH, pick_value(flavour), hold);
          hold = 1'b0;
        end
        for (int i = 0; i < CAPACITY + 3 && op_queue.size() < 550; i++) begin
          add_op(MODE_POP, value_t'($urandom), 1'b0);
        end
      end else begin
        len      = $urandom_range(60, 20);
        push_pct = $urandom_range(75, 30);
        for (int i = 0; i < len && op_queue.size() < 550; i++) begin
          if ($urandom_range(99) < push_pct) begin
            add_op(MODE_PUSH, pick_value(pick_flavour()), hold);
          end else begin
            add_op(MODE_POP, value_t'($urandom), hold);
          end
          hold = 1'b0;
        end
      end
      kind = ($urandom_range(99) < 15) ? 0 : 1;
      hold = ($urandom_range(99) < 25);
    end
  end

  // Driver: a word is held until it is taken, then replaced by the next one
  // or by an idle cycle. The payload carries random junk while idle.
  always @(negedge clk_i) begin : drive_ops
    heap_op_t op;
    if (rst_ni && (!in_if.valid || op_taken)) begin
      if (op_queue.size() != 0 && !(op_queue[0].hold_back && results_due.size() != 0)
          && (steady || $urandom_range(99) >= 30)) begin
        op          = op_queue.pop_front();
        in_if.valid <= 1'b1;
        in_if.mode  <= op.mode;
        in_if.value <= op.value;
      end else begin
        in_if.valid <= 1'b0;
        in_if.mode  <= 1'($urandom_range(1));
        in_if.value <= value_t'($urandom);
      end
    end
  end

  // Receiver: random back-pressure, none during the steady stretch, and
  // ready held low throughout the long hold-off below.
  always @(negedge clk_i) begin
    out_if.ready <= rst_ni && !sink_hold && (steady || $urandom_range(99) >= 30);
  end

  // Once, the receiver stops taking results for a long while. The sender
  // keeps offering words, so the output register fills and the block then
  // stalls its input.
  initial begin
    wait (words_taken >= 150);
    @(negedge clk_i);
    sink_hold <= 1'b1;
    repeat (400) @(negedge clk_i);
    sink_hold <= 1'b0;
  end

  // Monitor: the result word is checked before any operation accepted at
  // the same edge is predicted, so a stray result can never be matched with
  // the word that has only just gone in.
  always @(posedge clk_i) begin : watch_words
    res_t want;
    res_t next;
    if (rst_ni) begin
      if (out_if.valid && out_if.ready) begin
        if (results_due.size() == 0) begin
          report_mismatch("result word with no operation outstanding");
        end else begin
          want = results_due.pop_front();
          if (out_if.popped !== want.popped) begin
            report_mismatch($sformatf("popped %0d, expected %0d", out_if.popped, want.popped));
          end
          if (out_if.status !== want.status) begin
            report_mismatch($sformatf("status %0d, expected %s", out_if.status,
                                      want.status.name()));
          end
          if (out_if.count !== want.count) begin
            report_mismatch($sformatf("count %0d, expected %0d", out_if.count, want.count));
          end
        end
      end
      op_taken <= in_if.valid && in_if.ready;
      if (in_if.valid && in_if.ready) begin
        apply_heap_op(mode_e'(in_if.mode), in_if.value, next);
        results_due.push_back(next);
        words_taken <= words_taken + 1;
      end
    end
  end

  // End of run: all words sent, all results in, then a short quiet spell to
  // catch any result word that should never have appeared.
  initial begin
    @(posedge rst_ni);
    while (op_queue.size() != 0 || in_if.valid) @(posedge clk_i);
    while (results_due.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("max_heap_priority_queue verification clean");
    end else begin
      $display("max_heap_priority_queue verification failed");
    end
    $finish;
  end

  // A correct run needs well under half a millisecond, even with every pop
  // at its longest and the long receiver hold-off.
  initial begin
    #5_000_000;
    $display("max_heap_priority_queue verification failed");
    $finish;
  end

endmodule
